/* rtl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the deque block
// Request codes, status codes and fixed payload widths of the channels.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request codes; code 7 is unused and acts as a no-op
   typedef enum logic [TYPE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_PEEK_FRONT = 3'd5,
      OP_PEEK_BACK  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

/* rtl/dq_req_if.sv */
// ----------------------------------------------------------------------------
// dq_req_if: request channel
// Valid/ready channel carrying one request beat (code and value).
// ----------------------------------------------------------------------------
interface dq_req_if;
   import dq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [TYPE_W-1:0]          req_type;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);

endinterface

/* rtl/dq_rsp_if.sv */
// ----------------------------------------------------------------------------
// dq_rsp_if: response channel
// Valid/ready channel carrying one result beat (data, status, count).
// ----------------------------------------------------------------------------
interface dq_rsp_if;
   import dq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  data;
   status_type                 status;
   logic [COUNT_W-1:0]         count;

   modport source (output valid, output data, output status, output count, input ready);
   modport sink   (input valid, input data, input status, input count, output ready);

endinterface

/* rtl/dq_store.sv */
// ----------------------------------------------------------------------------
// dq_store: entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dq_store #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/dq_slot_unit.sv */
// ----------------------------------------------------------------------------
// dq_slot_unit: shared circular index adder
// Computes (base + offset) mod DEPTH with one add and one compare-subtract.
// ----------------------------------------------------------------------------
module dq_slot_unit #(
   parameter int DEPTH = 16
) (
   input  logic [$clog2(DEPTH)-1:0]    base,
   input  logic [$clog2(DEPTH+1)-1:0]  offset,
   output logic [$clog2(DEPTH)-1:0]    slot
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int SUM_W = CNT_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   // base < DEPTH and offset <= DEPTH, so one subtract is enough
   always_comb begin
      sum     = SUM_W'(base) + SUM_W'(offset);
      wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
      slot    = wrapped[IDX_W-1:0];
   end

endmodule

/* rtl/deque_with_remove_by_value.sv */
// ----------------------------------------------------------------------------
// deque_with_remove_by_value: bounded double-ended queue with remove by value
// Circular entry memory, one shared index adder, and a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: push, no-op and refused requests go from S_DECIDE to S_FINISH,
//   pop and peek pass through S_TAKE, and remove reads then compares each
//   entry scanned and reads then writes each entry moved, since the entry
//   memory has a single read port with a registered read.
// Throughput: one request at a time; a new beat is taken once the previous
//   result sits in the output register.
// Reset: synchronous, active high; empties the queue, front index to zero,
//   entry memory is left as is.
// ----------------------------------------------------------------------------
module deque_with_remove_by_value #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   dq_req_if.sink      req_if,
   dq_rsp_if.source    rsp_if
);
   import dq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   typedef enum logic [2:0] {
      S_IDLE,      // waiting for a request beat
      S_DECIDE,    // push done here, reads issued for pop and peek
      S_TAKE,      // read data back for pop and peek
      S_SCAN_RD,   // remove: read entry under scan
      S_SCAN_CMP,  // remove: compare entry with value
      S_SHIFT_RD,  // remove: read the entry behind the gap
      S_SHIFT_WR,  // remove: move it one place toward the front
      S_FINISH     // load the output register
   } state_type;

   state_type              state_ff, state_in;
   logic [TYPE_W-1:0]      op_ff, op_in;
   logic [DATA_WIDTH-1:0]  word_ff, word_in;
   logic [IDX_W-1:0]       front_ff, front_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;      // scan index, then move index
   logic [IDX_W-1:0]       addr_ff, addr_in;    // scan slot, then gap slot
   logic [DATA_WIDTH-1:0]  res_word_ff, res_word_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_data_ff, rsp_data_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // shared index adder
   logic [IDX_W-1:0]       unit_base;
   logic [CNT_W-1:0]       unit_off;
   logic [IDX_W-1:0]       unit_slot;

   // entry memory ports
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]  rd_data;

   // width helpers
   logic [CNT_W:0]               count_ext;
   logic [CNT_W:0]               pos_next;
   logic                         is_full;
   logic                         is_empty;
   logic [DATA_WIDTH+VALUE_W-1:0] in_ext;
   logic [DATA_WIDTH+VALUE_W-1:0] out_ext;
   logic [CNT_W+COUNT_W-1:0]     cnt_out_ext;

   dq_slot_unit #(.DEPTH(DEPTH)) u_slot (
      .base   (unit_base),
      .offset (unit_off),
      .slot   (unit_slot)
   );

   dq_store #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_ext = {1'b0, count_ff};
      pos_next  = {1'b0, pos_ff} + 1'b1;
      is_full   = (count_ff == CNT_W'(DEPTH));
      is_empty  = (count_ff == '0);
      // incoming word: sign-extend from 32 bits, then cut to the stored width
      in_ext      = {{DATA_WIDTH{req_if.value[VALUE_W-1]}}, req_if.value};
      // outgoing word: stored bits, zero-filled or cut to 32 bits
      out_ext     = {{VALUE_W{1'b0}}, res_word_ff};
      cnt_out_ext = {{COUNT_W{1'b0}}, count_ff};
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      word_in       = word_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      res_word_in   = res_word_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      unit_base = front_ff;
      unit_off  = CNT_W'(1);
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = rd_data;
      rd_addr   = addr_ff;

      // result beat taken downstream
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.req_type;
               word_in  = in_ext[DATA_WIDTH-1:0];
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            res_status_in = ST_OK;
            res_word_in   = '0;
            state_in      = S_FINISH;
            case (op_ff)
               OP_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     unit_off = CNT_W'(DEPTH - 1);   // front - 1, wrapped
                     wr_en    = 1'b1;
                     wr_addr  = unit_slot;
                     wr_data  = word_ff;
                     front_in = unit_slot;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     unit_off = count_ff;
                     wr_en    = 1'b1;
                     wr_addr  = unit_slot;
                     wr_data  = word_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_POP_FRONT, OP_PEEK_FRONT: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_addr  = front_ff;
                     state_in = S_TAKE;
                  end
               end
               OP_POP_BACK, OP_PEEK_BACK: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     unit_off = count_ff - 1'b1;
                     rd_addr  = unit_slot;
                     state_in = S_TAKE;
                  end
               end
               OP_REMOVE: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     addr_in  = front_ff;
                     pos_in   = '0;
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
                  // unused code: no-op, ok status
               end
            endcase
         end

         S_TAKE: begin
            res_word_in = rd_data;
            if (op_ff == OP_POP_FRONT) begin
               front_in = unit_slot;           // front + 1, wrapped
               count_in = count_ff - 1'b1;
            end else if (op_ff == OP_POP_BACK) begin
               count_in = count_ff - 1'b1;
            end
            state_in = S_FINISH;
         end

         S_SCAN_RD: begin
            rd_addr  = addr_ff;
            state_in = S_SCAN_CMP;
         end

         S_SCAN_CMP: begin
            unit_base = addr_ff;
            if (rd_data == word_ff) begin
               res_word_in = rd_data;
               if (pos_next < count_ext) begin
                  state_in = S_SHIFT_RD;       // gap sits at addr_ff
               end else begin
                  count_in = count_ff - 1'b1;  // match was the back entry
                  state_in = S_FINISH;
               end
            end else if (pos_next < count_ext) begin
               pos_in   = pos_next[CNT_W-1:0];
               addr_in  = unit_slot;
               state_in = S_SCAN_RD;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_FINISH;
            end
         end

         S_SHIFT_RD: begin
            unit_base = addr_ff;
            rd_addr   = unit_slot;
            state_in  = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            unit_base = addr_ff;
            wr_en     = 1'b1;
            wr_addr   = addr_ff;
            wr_data   = rd_data;
            addr_in   = unit_slot;
            pos_in    = pos_next[CNT_W-1:0];
            if ((pos_next + 1'b1) < count_ext) begin
               state_in = S_SHIFT_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = out_ext[VALUE_W-1:0];
               rsp_status_in = res_status_ff;
               rsp_count_in  = cnt_out_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         word_ff       <= word_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         addr_ff       <= addr_in;
         res_word_ff   <= res_word_in;
         res_status_ff <= res_status_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_data_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.count  = rsp_count_ff;

   // fill count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= (CNT_W+1)'(DEPTH))
      else $error("fill count above capacity");

   // a request moves the fill count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ext == ({1'b0, $past(count_ff)} + 1'b1)) ||
          ((count_ext + 1'b1) == {1'b0, $past(count_ff)})))
      else $error("fill count jumped");

   // failed requests return zero data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status != ST_OK)) |-> (rsp_if.data == '0))
      else $error("nonzero data on failed request");

   // memory is only written while a request is in work
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !req_if.ready)
      else $error("memory write while idle");

endmodule

/* bench/dq_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_result_checker: scoreboard for the deque block
// Watches both channels and keeps its own copy of the deque. Every accepted
// request is replayed against that copy. Each result beat is then compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module dq_result_checker (
   input  logic clock,
   input  logic reset,
   dq_req_if    req_if,
   dq_rsp_if    rsp_if,
   output int   mismatches,
   output int   outstanding
);
   import dq_pkg::*;

   localparam int DEPTH = 16;

   typedef struct packed {
      logic signed [VALUE_W-1:0] data;
      status_type                status;
      logic [COUNT_W-1:0]        count;
   } dq_result_type;

   // shadow of the deque: circular store, front slot, fill level
   logic signed [VALUE_W-1:0] words [DEPTH];
   logic [3:0]                head;
   logic [COUNT_W-1:0]        held;
   dq_result_type             results_due [$];
   int                        errors = 0;

   function automatic logic [3:0] slot(input int offset);
      return head + offset[3:0];
   endfunction

   // apply one request to the shadow and return the result it must produce
   task automatic apply_request(input logic [TYPE_W-1:0] code,
                                input logic signed [VALUE_W-1:0] v,
                                output dq_result_type r);
      int hit;
      int i;
      r.data   = '0;
      r.status = ST_OK;
      case (code)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held == DEPTH) begin
               r.status = ST_FULL;
            end else if (code == OP_PUSH_FRONT) begin
               head = head - 1'b1;
               words[head] = v;
               held = held + 1'b1;
            end else begin
               words[slot(held)] = v;
               held = held + 1'b1;
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = words[head];
               if (code == OP_POP_FRONT) begin
                  head = head + 1'b1;
                  held = held - 1'b1;
               end
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = words[slot(held - 1)];
               if (code == OP_POP_BACK) held = held - 1'b1;
            end
         end
         OP_REMOVE: begin
            hit = -1;
            for (i = 0; i < held; i++)
               if (hit < 0 && words[slot(i)] == v) hit = i;
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.data = words[slot(hit)];
               // later entries slide one place toward the front
               for (i = hit; i + 1 < held; i++)
                  words[slot(i)] = words[slot(i + 1)];
               held = held - 1'b1;
            end
         end
         default: ;  // unused code: no-op
      endcase
      r.count = held;
   endtask

   always @(posedge clock) begin
      dq_result_type want;
      if (reset) begin
         head = '0;
         held = '0;
         results_due.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (results_due.size() == 0) begin
               $error("result beat with nothing expected: data %0d status %0d count %0d",
                      rsp_if.data, rsp_if.status, rsp_if.count);
               errors++;
            end else begin
               want = results_due.pop_front();
               if (rsp_if.data !== want.data) begin
                  $error("data: expected %0d, got %0d", want.data, rsp_if.data);
                  errors++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  errors++;
               end
               if (rsp_if.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_if.count);
                  errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            apply_request(req_if.req_type, req_if.value, want);
            results_due.push_back(want);
         end
      end
      mismatches  <= errors;
      outstanding <= results_due.size();
   end

endmodule

/* bench/tb_deque_with_remove_by_value.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_remove_by_value: regression bench for the deque block
// A short directed run covers empty and not-found cases, extreme words and
// the no-op code. Then come random phases that lean toward filling, searching
// or draining. Both sides stall at random, and two long receiver hold-offs
// back up the block. Checking lives in dq_result_checker.
// ----------------------------------------------------------------------------
module tb_deque_with_remove_by_value;
   import dq_pkg::*;

   localparam logic [TYPE_W-1:0] OP_NOP = 3'd7;   // unused code, acts as no-op
   localparam int IDLE_MAX      = 17;
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 48;    // longer than the slowest remove
   localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
   localparam int PHASES        = 12;
   localparam int PHASE_BEATS   = 140;

   // small pool so that removes often hit; includes both extremes
   localparam logic signed [VALUE_W-1:0] VALUE_POOL [6] = '{
      32'sh0000_0000, 32'sh0000_0001, 32'shffff_ffff,
      32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0007
   };

   typedef enum int {MIX_FILL, MIX_SEARCH, MIX_BALANCED, MIX_DRAIN} mix_type;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   bit   req_steady;     // sender offers back to back
   bit   rsp_steady;     // receiver skips random stalls
   bit   hold_request;   // ask the receiver for one long hold-off

   dq_req_if req_if ();
   dq_rsp_if rsp_if ();

   deque_with_remove_by_value i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   dq_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // request side helpers
   // ---------------------------------------------------------------------

   // offer one beat after a random gap; returns in the step of acceptance,
   // with valid still high so the next beat can follow without a bubble
   task automatic send_beat(input logic [TYPE_W-1:0] code,
                            input logic signed [VALUE_W-1:0] v);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= code;
      req_if.value    <= v;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // sender pause: drop valid and wait until every result is back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [TYPE_W-1:0] pick_op(input mix_type mix);
      int push_pct;
      int remove_pct;
      int r;
      case (mix)
         MIX_FILL:     begin push_pct = 70; remove_pct = 8;  end
         MIX_SEARCH:   begin push_pct = 40; remove_pct = 35; end
         MIX_BALANCED: begin push_pct = 45; remove_pct = 15; end
         default:      begin push_pct = 20; remove_pct = 10; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (r < push_pct + remove_pct) return OP_REMOVE;
      if (r >= 97) return OP_NOP;
      case ($urandom_range(0, 3))
         0:       return OP_POP_FRONT;
         1:       return OP_POP_BACK;
         2:       return OP_PEEK_FRONT;
         default: return OP_PEEK_BACK;
      endcase
   endfunction

   // mostly pool words (for matches), otherwise any 32-bit word
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 7) return VALUE_POOL[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   // ---------------------------------------------------------------------
   // response side: random stall per beat, plus the long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = rsp_steady ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without a beat on either channel ends the run
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("deque_with_remove_by_value regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and verdict
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int      phase;
      int      n;
      mix_type mix;
      req_steady   = 1'b0;
      rsp_steady   = 1'b0;
      hold_request = 1'b0;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.req_type <= OP_NOP;
      req_if.value    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty deque: every read-type request is refused, no-op keeps count
      send_beat(OP_POP_FRONT,  '0);
      send_beat(OP_POP_BACK,   '0);
      send_beat(OP_PEEK_FRONT, '0);
      send_beat(OP_PEEK_BACK,  '0);
      send_beat(OP_REMOVE,     '0);
      send_beat(OP_NOP,        32'sh1234_5678);
      // extremes at both ends, then peeks
      send_beat(OP_PUSH_FRONT, 32'sh8000_0000);
      send_beat(OP_PUSH_BACK,  32'sh7fff_ffff);
      send_beat(OP_PUSH_FRONT, 32'shffff_ffff);
      send_beat(OP_PUSH_BACK,  32'sh0000_0000);
      send_beat(OP_PEEK_FRONT, '0);
      send_beat(OP_PEEK_BACK,  '0);
      // miss, then hit in the middle so later entries close the gap
      send_beat(OP_REMOVE,     32'sh0000_3039);
      send_beat(OP_REMOVE,     32'sh8000_0000);
      send_beat(OP_NOP,        32'shffff_ffff);
      send_beat(OP_POP_FRONT,  '0);
      send_beat(OP_POP_BACK,   '0);
      send_beat(OP_POP_FRONT,  '0);   // last entry out
      // duplicates: remove takes the one nearest the front
      send_beat(OP_PUSH_BACK,  32'sh5555_5555);
      send_beat(OP_PUSH_BACK,  32'shaaaa_aaaa);
      send_beat(OP_PUSH_BACK,  32'sh5555_5555);
      send_beat(OP_REMOVE,     32'sh5555_5555);
      send_beat(OP_REMOVE,     32'shaaaa_aaaa);
      send_beat(OP_POP_BACK,   '0);
      wait_drained();

      // random phases; fill phases run into full, drain phases into empty
      for (phase = 0; phase < PHASES; phase++) begin
         mix        = mix_type'(phase % 4);
         req_steady = (phase % 3 == 2);
         rsp_steady = req_steady;
         // long back-pressure while the sender keeps offering
         if (phase == 0 || phase == 8) hold_request = 1'b1;
         for (n = 0; n < PHASE_BEATS; n++)
            send_beat(pick_op(mix), pick_value());
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("deque_with_remove_by_value regression: pass");
      else
         $display("deque_with_remove_by_value regression: fail");
      $finish;
   end

endmodule
